// File: design/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared constants and codes for the smooth weighted round-robin chooser.
// ----------------------------------------------------------------------------
package swrr_pkg;

    // Default configuration of the chooser.
    localparam int DEF_NUM_ENDPOINTS = 8;
    localparam int DEF_WEIGHT_BITS   = 8;

    // Register file: eight weight registers, addressed by a four-bit index so
    // that writes beyond the list can be seen and ignored.
    localparam int NUM_REGS       = 8;
    localparam int CFG_INDEX_BITS = 4;

    // Fixed field widths of the request and result channels.
    localparam int TARGET_BITS = 3;
    localparam int CHOSEN_BITS = 3;
    localparam int STATUS_BITS = 2;

    // Request modes.
    localparam logic MODE_SELECT = 1'b0;
    localparam logic MODE_HEALTH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_CHOSEN = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NONE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_HEALTH = 2'd2;

endpackage

// File: design/smooth_weighted_round_robin.sv
// ----------------------------------------------------------------------------
// smooth_weighted_round_robin
// Smooth weighted round-robin chooser over up to eight endpoints.
// A request is held in the input register, goes through the select pass and
// lands in the result register, from which the consumer takes it.
// Throughput: one request per cycle while the consumer keeps up, set by the
// select pass (increment, compare scan and winner subtract) between the two registers.
// Reset: synchronous, active low; weights return to 1, every endpoint is
// healthy, every current weight is zero and both stages are empty.
// ----------------------------------------------------------------------------
module smooth_weighted_round_robin
    import swrr_pkg::*;
#(
    parameter int NUM_ENDPOINTS = DEF_NUM_ENDPOINTS,
    parameter int WEIGHT_BITS   = DEF_WEIGHT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [TARGET_BITS-1:0]    i_target_index,
    input  logic                      i_set_healthy,

    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STATUS_BITS-1:0]    o_status,
    output logic [CHOSEN_BITS-1:0]    o_chosen_index,

    // Configuration write channel.
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [WEIGHT_BITS-1:0]    i_cfg_data
);

    // The current weights carry five bits of headroom over a weight and
    // saturate at the limits of their signed range. One extra bit holds an
    // unsaturated add or subtract, and the total of the eligible weights
    // needs as many extra bits as it takes to number the endpoints.
    localparam int EP_IDX_BITS = $clog2(NUM_ENDPOINTS);
    localparam int CUR_BITS    = WEIGHT_BITS + 5;
    localparam int EXT_BITS    = CUR_BITS + 1;
    localparam int TOT_BITS    = WEIGHT_BITS + EP_IDX_BITS;

    localparam logic [CUR_BITS-1:0] CUR_MAX = {1'b0, {(CUR_BITS-1){1'b1}}};
    localparam logic [CUR_BITS-1:0] CUR_MIN = {1'b1, {(CUR_BITS-1){1'b0}}};

    // Clamp an extended result back into the current-weight range. The
    // result has overflowed when its two top bits disagree, and the top bit
    // then tells which limit applies.
    function automatic logic [CUR_BITS-1:0] sat_cur(input logic [EXT_BITS-1:0] value);
        logic [CUR_BITS-1:0] result;
        if (value[EXT_BITS-1] != value[EXT_BITS-2]) begin
            result = value[EXT_BITS-1] ? CUR_MIN : CUR_MAX;
        end else begin
            result = value[CUR_BITS-1:0];
        end
        return result;
    endfunction

    // ------------------------------------------------------------------
    // State: weights, health bits and signed current weights.
    // ------------------------------------------------------------------
    logic [WEIGHT_BITS-1:0] r_weight [NUM_ENDPOINTS];
    logic                   r_health [NUM_ENDPOINTS];
    logic [CUR_BITS-1:0]    r_cur    [NUM_ENDPOINTS];

    // Input register: one request waiting for the select pass.
    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [TARGET_BITS-1:0] r_in_target;
    logic                   r_in_healthy;

    // Result register.
    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [CHOSEN_BITS-1:0] r_out_chosen;

    // The select pass moves forward whenever the result register is empty
    // or its result is being taken in this cycle. The input register takes
    // a new request whenever it is empty or its request moves on, so one
    // request per cycle flows through while the consumer keeps up.
    logic advance;
    logic fire;
    logic cfg_write;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign cfg_write  = i_cfg_valid && o_cfg_ready && (32'(i_cfg_index) < NUM_REGS);

    // ------------------------------------------------------------------
    // Select pass.
    // Every eligible endpoint (healthy, weight not zero) has its current
    // weight raised by its weight, with saturation. A scan from endpoint 0
    // upwards keeps the first strictly largest positive value, so ties go
    // to the lowest index. The winner then loses the total of the eligible
    // weights. When no endpoint holds a positive value the increments still
    // stand and the result reports that no endpoint was chosen.
    // ------------------------------------------------------------------
    logic [CUR_BITS-1:0]    n_inc [NUM_ENDPOINTS];
    logic [CUR_BITS-1:0]    n_cur [NUM_ENDPOINTS];
    logic [TOT_BITS-1:0]    n_total;
    logic [CUR_BITS-1:0]    n_best;
    logic [EP_IDX_BITS-1:0] n_win;
    logic                   n_found;
    logic [CUR_BITS-1:0]    n_win_cur;

    always_comb begin
        logic                elig;
        logic [EXT_BITS-1:0] sum_ext;
        n_total = '0;
        n_best  = '0;
        n_win   = '0;
        n_found = 1'b0;
        for (int i = 0; i < NUM_ENDPOINTS; i++) begin
            elig    = r_health[i] && (r_weight[i] != '0);
            sum_ext = {r_cur[i][CUR_BITS-1], r_cur[i]}
                    + {{(EXT_BITS-WEIGHT_BITS){1'b0}}, r_weight[i]};
            n_inc[i] = elig ? sat_cur(sum_ext) : r_cur[i];
            if (elig) begin
                n_total = n_total + {{(TOT_BITS-WEIGHT_BITS){1'b0}}, r_weight[i]};
                if ($signed(n_inc[i]) > $signed(n_best)) begin
                    n_best  = n_inc[i];
                    n_win   = EP_IDX_BITS'(i);
                    n_found = 1'b1;
                end
            end
        end
        n_win_cur = sat_cur({n_best[CUR_BITS-1], n_best}
                          - {{(EXT_BITS-TOT_BITS){1'b0}}, n_total});
        // Next current weights: the increments, with the winner's reduced
        // value in its own slot.
        for (int i = 0; i < NUM_ENDPOINTS; i++) begin
            n_cur[i] = (n_found && (n_win == EP_IDX_BITS'(i))) ? n_win_cur : n_inc[i];
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_mode    <= i_mode;
            r_in_target  <= i_target_index;
            r_in_healthy <= i_set_healthy;
        end
    end

    // ------------------------------------------------------------------
    // State update. A health update writes one health bit when its target
    // names an endpoint that exists. A select request stores the increments
    // and the winner's reduced value. A configuration write to one of the eight
    // registers clears every current weight; it is to arrive only while the
    // block is idle, which the block itself does not enforce (a write wins over a
    // select request in the same cycle). Registers at or above the endpoint count are unused.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                r_weight[i] <= WEIGHT_BITS'(1);
                r_health[i] <= 1'b1;
                r_cur[i]    <= '0;
            end
        end else begin
            if (fire && (r_in_mode == MODE_HEALTH)) begin
                if (32'(r_in_target) < NUM_ENDPOINTS) begin
                    r_health[r_in_target[EP_IDX_BITS-1:0]] <= r_in_healthy;
                end
            end
            if (cfg_write) begin
                if (32'(i_cfg_index) < NUM_ENDPOINTS) begin
                    r_weight[i_cfg_index[EP_IDX_BITS-1:0]] <= i_cfg_data;
                end
                for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                    r_cur[i] <= '0;
                end
            end else if (fire && (r_in_mode == MODE_SELECT)) begin
                for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                    r_cur[i] <= n_cur[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_in_mode == MODE_HEALTH) begin
                r_out_status <= STATUS_HEALTH;
                r_out_chosen <= '0;
            end else if (n_found) begin
                r_out_status <= STATUS_CHOSEN;
                r_out_chosen <= CHOSEN_BITS'(n_win);
            end else begin
                r_out_status <= STATUS_NONE;
                r_out_chosen <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_chosen_index = r_out_chosen;

endmodule

// File: design/swrr_checker.sv
// ----------------------------------------------------------------------------
// swrr_checker
// Port-level checks for the smooth weighted round-robin chooser.
// ----------------------------------------------------------------------------
module swrr_checker
    import swrr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_BITS-1:0] o_status,
    input logic [CHOSEN_BITS-1:0] o_chosen_index
);

    // Only a chosen result carries an endpoint number.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STATUS_CHOSEN)) |-> (o_chosen_index == '0))
        else $error("result without a chosen endpoint carries a non-zero index");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_chosen_index)))
        else $error("stalled result changed or dropped");

    // Nothing leaves the block straight after a reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind smooth_weighted_round_robin swrr_checker u_swrr_checker (.*);
